/* rtl/bsa_pkg.sv */
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int LEAF_WORDS_DEF = 63;
  localparam int LEAF_BITS      = 64;
  localparam int LEAF_POS_W     = 6;
  localparam int SLOT_W         = 12;
  localparam int OFF_W          = 20;
  localparam int SHIFT_W        = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OUT      = 2'd2,
    ST_MISALIGN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOCATE = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic                  any;
    logic [LEAF_POS_W-1:0] pos;
  } lsb_res_t;

endpackage

/* rtl/bsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bsa_lsb_find.sv */
// Lowest-set-bit finder shared by the summary and leaf searches.
module bsa_lsb_find (
  input  logic [bsa_pkg::LEAF_BITS-1:0] operand,
  output bsa_pkg::lsb_res_t             res
);

  logic [bsa_pkg::LEAF_BITS-1:0]  iso;
  logic [bsa_pkg::LEAF_POS_W-1:0] pos;

  assign iso = operand & (~operand + bsa_pkg::LEAF_BITS'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < bsa_pkg::LEAF_BITS; i++) begin
      if (iso[i]) begin
        pos = pos | bsa_pkg::LEAF_POS_W'(i);
      end
    end
  end

  assign res.any = |operand;
  assign res.pos = pos;

endmodule

/* rtl/bitmap_slot_allocator.sv */
// Two-level bitmap slot allocator: LEAF_WORDS x 64 slots, one free bit per slot in a leaf RAM
// and one summary bit per leaf word in flops. A transaction is accepted in the idle cycle, then
// takes a locate cycle (summary search or free-offset checks, leaf read issued) and an update
// cycle (leaf search, write-back, result registered). A new transaction is accepted only once
// the update is done and the state is idle again; one lowest-bit finder serves both locate
// and update. The result register lets the next transaction be accepted while a result waits;
// the update stalls only if the previous result is still untaken. Leaf words read as all free
// until first written, so no clearing pass follows reset. Freeing a free slot returns ok.
module bitmap_slot_allocator #(
  parameter int LEAF_WORDS = bsa_pkg::LEAF_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bsa_pkg::SHIFT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [bsa_pkg::OFF_W-1:0]     free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [bsa_pkg::SLOT_W-1:0]    slot_index,
  output logic [bsa_pkg::OFF_W-1:0]     byte_offset
);

  localparam int WORD_W = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
  localparam int SLOTS  = LEAF_WORDS * bsa_pkg::LEAF_BITS;

  bsa_pkg::state_t                 state, state_next;
  logic [bsa_pkg::SHIFT_W-1:0]     slot_shift;
  logic [bsa_pkg::SHIFT_W-1:0]     sh_eff;
  logic [LEAF_WORDS-1:0]           summary, summary_next;
  logic [LEAF_WORDS-1:0]           leaf_valid;
  logic                            op_mode;
  logic [bsa_pkg::OFF_W-1:0]       op_off;
  bsa_pkg::status_t                cur_status, loc_status;
  logic [WORD_W-1:0]               cur_word, loc_word;
  logic [bsa_pkg::LEAF_POS_W-1:0]  cur_bit, loc_bit;

  logic [bsa_pkg::OFF_W-1:0]       off_slot;
  logic                            misalign;
  logic [bsa_pkg::LEAF_BITS-1:0]   find_op;
  bsa_pkg::lsb_res_t               find_res;
  logic [bsa_pkg::LEAF_BITS-1:0]   rd_data;
  logic [bsa_pkg::LEAF_BITS-1:0]   leaf, leaf_new;
  logic [bsa_pkg::LEAF_POS_W-1:0]  upd_bit;
  logic [bsa_pkg::SLOT_W-1:0]      upd_idx;
  logic [bsa_pkg::OFF_W-1:0]       upd_boff;
  logic                            rd_en, wr_en, upd_go;

  always_comb begin
    if (slot_shift < bsa_pkg::SHIFT_MIN) begin
      sh_eff = bsa_pkg::SHIFT_MIN;
    end else if (slot_shift > bsa_pkg::SHIFT_MAX) begin
      sh_eff = bsa_pkg::SHIFT_MAX;
    end else begin
      sh_eff = slot_shift;
    end
  end

  assign off_slot = op_off >> sh_eff;
  assign misalign = |(op_off & ~({bsa_pkg::OFF_W{1'b1}} << sh_eff));
  assign leaf     = leaf_valid[cur_word] ? rd_data : '1;
  assign find_op  = (state == bsa_pkg::S_LOCATE) ? bsa_pkg::LEAF_BITS'(summary) : leaf;

  bsa_lsb_find u_find (
    .operand (find_op),
    .res     (find_res)
  );

  always_comb begin
    loc_status = bsa_pkg::ST_OK;
    loc_word   = '0;
    loc_bit    = '0;
    if (op_mode == bsa_pkg::MODE_ALLOC) begin
      if (!find_res.any) begin
        loc_status = bsa_pkg::ST_FULL;
      end else begin
        loc_word = find_res.pos[WORD_W-1:0];
      end
    end else begin
      if (off_slot >= bsa_pkg::OFF_W'(SLOTS)) begin
        loc_status = bsa_pkg::ST_OUT;
      end else if (misalign) begin
        loc_status = bsa_pkg::ST_MISALIGN;
      end else begin
        loc_word = off_slot[bsa_pkg::LEAF_POS_W +: WORD_W];
        loc_bit  = off_slot[bsa_pkg::LEAF_POS_W-1:0];
      end
    end
  end

  assign rd_en = (state == bsa_pkg::S_LOCATE) && (loc_status == bsa_pkg::ST_OK);

  always_comb begin
    upd_bit = (op_mode == bsa_pkg::MODE_FREE) ? cur_bit : find_res.pos;
    if (op_mode == bsa_pkg::MODE_FREE) begin
      leaf_new = leaf | (bsa_pkg::LEAF_BITS'(1) << upd_bit);
    end else begin
      leaf_new = leaf & ~(bsa_pkg::LEAF_BITS'(1) << upd_bit);
    end
    upd_idx  = bsa_pkg::SLOT_W'({cur_word, upd_bit});
    upd_boff = bsa_pkg::OFF_W'(upd_idx) << sh_eff;
  end

  assign upd_go = (state == bsa_pkg::S_UPDATE) && (!out_valid || out_ready);
  assign wr_en  = upd_go && (cur_status == bsa_pkg::ST_OK);

  always_comb begin
    summary_next = summary;
    if (wr_en) begin
      summary_next[cur_word] = (op_mode == bsa_pkg::MODE_FREE) ? 1'b1 : |leaf_new;
    end
  end

  bsa_ram #(
    .WIDTH (bsa_pkg::LEAF_BITS),
    .DEPTH (LEAF_WORDS),
    .AW    (WORD_W)
  ) u_leaf_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_word),
    .wr_data (leaf_new),
    .rd_en   (rd_en),
    .rd_addr (loc_word),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      bsa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bsa_pkg::S_LOCATE;
        end
      end
      bsa_pkg::S_LOCATE: begin
        state_next = bsa_pkg::S_UPDATE;
      end
      bsa_pkg::S_UPDATE: begin
        if (upd_go) begin
          state_next = bsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bsa_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == bsa_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bsa_pkg::S_IDLE;
      slot_shift <= bsa_pkg::SHIFT_RESET;
      summary    <= '1;
      leaf_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      summary <= summary_next;
      if (cfg_wr_en) begin
        slot_shift <= cfg_wr_data;
      end
      if (wr_en) begin
        leaf_valid[cur_word] <= 1'b1;
      end
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode <= mode;
      op_off  <= free_offset;
    end
    if (state == bsa_pkg::S_LOCATE) begin
      cur_status <= loc_status;
      cur_word   <= loc_word;
      cur_bit    <= loc_bit;
    end
    if (upd_go) begin
      status <= cur_status;
      if (cur_status == bsa_pkg::ST_OK) begin
        slot_index  <= upd_idx;
        byte_offset <= upd_boff;
      end else begin
        slot_index  <= '0;
        byte_offset <= '0;
      end
    end
  end

endmodule

/* rtl/bsa_checker.sv */
// Port-level checker for the bitmap slot allocator, bound to the top level.
module bsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [bsa_pkg::SLOT_W-1:0]  slot_index,
  input logic [bsa_pkg::OFF_W-1:0]   byte_offset
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction dropped before acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
      && $stable(byte_offset))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after an accepted transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bsa_pkg::ST_OK) |-> (slot_index == '0) && (byte_offset == '0))
    else $error("error result carries nonzero slot fields");

  a_ok_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bsa_pkg::ST_OK) |-> (byte_offset[3:0] == 4'd0))
    else $error("ok result with misaligned byte offset");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .slot_index  (slot_index),
  .byte_offset (byte_offset)
);

/* tb/sv/tb_bitmap_slot_allocator.sv */
// Testbench for the bitmap slot allocator: directed and random requests checked against a model.
module tb_bitmap_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAF_WORDS = bsa_pkg::LEAF_WORDS_DEF;
  localparam int LEAF_BITS  = bsa_pkg::LEAF_BITS;
  localparam int SLOT_W     = bsa_pkg::SLOT_W;
  localparam int OFF_W      = bsa_pkg::OFF_W;
  localparam int SHIFT_W    = bsa_pkg::SHIFT_W;
  localparam int SLOT_COUNT = LEAF_WORDS * LEAF_BITS;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bsa_pkg::status_t  st;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  boff;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [SHIFT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = bsa_pkg::MODE_ALLOC;
  logic [OFF_W-1:0] free_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [OFF_W-1:0] byte_offset;

  // Model of the pool
  logic [LEAF_BITS-1:0]  slot_free [LEAF_WORDS];
  logic [LEAF_WORDS-1:0] leaf_has_free;
  logic [SHIFT_W-1:0]    shift_reg;

  alloc_resp_t expected_responses[$];
  int live_slots[$];
  bit burst = 1'b0;
  bit hold_req = 1'b0;
  int mismatch_count = 0;
  int request_count = 0;
  int n_alloc = 0, n_free = 0, n_full = 0, n_out = 0, n_mis = 0;

  bitmap_slot_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .free_offset (free_offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_index  (slot_index),
    .byte_offset (byte_offset)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_shift();
    if (shift_reg < bsa_pkg::SHIFT_MIN) return int'(bsa_pkg::SHIFT_MIN);
    if (shift_reg > bsa_pkg::SHIFT_MAX) return int'(bsa_pkg::SHIFT_MAX);
    return int'(shift_reg);
  endfunction

  function automatic int lowest_one(input logic [LEAF_BITS-1:0] v);
    for (int i = 0; i < LEAF_BITS; i++)
      if (v[i]) return i;
    return 0;
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < LEAF_WORDS; i++) slot_free[i] = '1;
    leaf_has_free = '1;
    shift_reg = bsa_pkg::SHIFT_RESET;
  endfunction

  function automatic alloc_resp_t model_request(input logic m, input logic [OFF_W-1:0] off);
    alloc_resp_t r;
    int sh, w, b, s, limit;
    r.st = bsa_pkg::ST_OK;
    r.slot = '0;
    r.boff = '0;
    sh = eff_shift();
    if (m == bsa_pkg::MODE_ALLOC) begin
      if (leaf_has_free == '0) begin
        r.st = bsa_pkg::ST_FULL;
      end else begin
        w = lowest_one(LEAF_BITS'(leaf_has_free));
        b = lowest_one(slot_free[w]);
        slot_free[w][b] = 1'b0;
        if (slot_free[w] == '0) leaf_has_free[w] = 1'b0;
        s = w * LEAF_BITS + b;
        r.slot = SLOT_W'(s);
        r.boff = OFF_W'(s << sh);
      end
    end else begin
      limit = SLOT_COUNT << sh;
      if (int'(off) >= limit) begin
        r.st = bsa_pkg::ST_OUT;
      end else if ((int'(off) & ((1 << sh) - 1)) != 0) begin
        r.st = bsa_pkg::ST_MISALIGN;
      end else begin
        s = int'(off) >> sh;
        w = s / LEAF_BITS;
        slot_free[w][s % LEAF_BITS] = 1'b1;
        leaf_has_free[w] = 1'b1;
        r.slot = SLOT_W'(s);
        r.boff = off;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic m, input logic [OFF_W-1:0] off);
    int gap;
    alloc_resp_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    free_offset <= off;
    do @(posedge clk); while (!in_ready);
    r = model_request(m, off);
    expected_responses.insert(expected_responses.size(), r);
    if (m == bsa_pkg::MODE_ALLOC && r.st == bsa_pkg::ST_OK)
      live_slots.insert(live_slots.size(), int'(r.slot));
    request_count++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] v);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    shift_reg = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_slot(input int s);
    send_request(bsa_pkg::MODE_FREE, OFF_W'(s << eff_shift()));
  endtask

  task automatic test_basic_alloc();
    repeat (4) send_request(bsa_pkg::MODE_ALLOC, OFF_W'($urandom));
    free_slot(0);
    free_slot(2);
    repeat (3) send_request(bsa_pkg::MODE_ALLOC, '0);
  endtask

  task automatic test_free_errors();
    send_request(bsa_pkg::MODE_FREE, OFF_W'(SLOT_COUNT << 4));
    send_request(bsa_pkg::MODE_FREE, '1);
    send_request(bsa_pkg::MODE_FREE, OFF_W'((SLOT_COUNT << 4) - 1));
    send_request(bsa_pkg::MODE_FREE, OFF_W'(1));
    free_slot(SLOT_COUNT - 1);
    free_slot(1);
    free_slot(1);
  endtask

  task automatic test_shift_config();
    write_shift(4'd0);
    send_request(bsa_pkg::MODE_ALLOC, '0);
    write_shift(4'd15);
    send_request(bsa_pkg::MODE_FREE, '1);
    send_request(bsa_pkg::MODE_FREE, OFF_W'(SLOT_COUNT << 8));
    send_request(bsa_pkg::MODE_FREE, OFF_W'((SLOT_COUNT << 8) - 1));
    send_request(bsa_pkg::MODE_FREE, OFF_W'(8'h80));
    free_slot(SLOT_COUNT - 1);
    send_request(bsa_pkg::MODE_ALLOC, '0);
    write_shift(bsa_pkg::SHIFT_MAX);
    send_request(bsa_pkg::MODE_ALLOC, '1);
    write_shift(4'd5);
    send_request(bsa_pkg::MODE_ALLOC, '0);
    free_slot(1);
  endtask

  task automatic test_random_mix();
    int r, sh, k, limit;
    logic [SHIFT_W-1:0] v;
    for (int p = 0; p < 5; p++) begin
      if (p == 0) v = bsa_pkg::SHIFT_MIN;
      else if (p == 1) v = bsa_pkg::SHIFT_MAX;
      else v = SHIFT_W'($urandom_range(0, 15));
      write_shift(v);
      sh = eff_shift();
      limit = SLOT_COUNT << sh;
      for (int i = 0; i < 120; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 80 && live_slots.size() == 0)) begin
          send_request(bsa_pkg::MODE_ALLOC, OFF_W'($urandom));
        end else if (r < 80) begin
          k = $urandom_range(0, live_slots.size() - 1);
          free_slot(live_slots[k]);
          live_slots.delete(k);
        end else if (r < 88) begin
          send_request(bsa_pkg::MODE_FREE,
                       OFF_W'(($urandom_range(0, SLOT_COUNT - 1) << sh) |
                              $urandom_range(1, (1 << sh) - 1)));
        end else if (r < 94) begin
          send_request(bsa_pkg::MODE_FREE, OFF_W'($urandom_range(limit, (1 << OFF_W) - 1)));
        end else begin
          send_request(bsa_pkg::MODE_FREE, OFF_W'($urandom));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    int s;
    burst = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 && live_slots.size() != 0) begin
        s = live_slots[live_slots.size() - 1];
        live_slots.delete(live_slots.size() - 1);
        free_slot(s);
      end else begin
        send_request(bsa_pkg::MODE_ALLOC, OFF_W'($urandom));
      end
    end
    burst = 1'b0;
    wait_quiet();
  endtask

  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (burst) begin
        out_ready <= 1'b1;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(0, 7)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          if (r < 90) repeat ($urandom_range(0, 2)) @(posedge clk);
          else if (r < 98) repeat ($urandom_range(3, 11)) @(posedge clk);
          else repeat ($urandom_range(19, 49)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_responses
    alloc_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response: status %0d slot_index %0d byte_offset %0d",
               status, slot_index, byte_offset);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d actual %0d", want.st, status);
          mismatch_count++;
        end
        if (slot_index !== want.slot) begin
          $error("slot_index: expected %0d actual %0d", want.slot, slot_index);
          mismatch_count++;
        end
        if (byte_offset !== want.boff) begin
          $error("byte_offset: expected %0d actual %0d", want.boff, byte_offset);
          mismatch_count++;
        end
        case (want.st)
          bsa_pkg::ST_OK: begin
          end
          bsa_pkg::ST_FULL: n_full++;
          bsa_pkg::ST_OUT: n_out++;
          default: n_mis++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (mode == bsa_pkg::MODE_ALLOC) n_alloc++;
      else n_free++;
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    reset_pool();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_alloc();
    test_free_errors();
    test_shift_config();
    test_random_mix();
    test_backpressure();
    $display("ran %0d requests (%0d allocate, %0d free)", request_count, n_alloc, n_free);
    $display("shift settings 0, 4, 5, 8, 15 and random; %0d full, %0d out, %0d misaligned",
             n_full, n_out, n_mis);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
